// ===== design/bsa_pkg.sv =====
package bsa_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int FIELD_W      = 64;
    localparam int IDX_W        = 8;
    localparam int CNT_OUT_W    = 9;
    localparam int CMD_W        = 2;
    localparam int KEY_W        = 2;
    localparam int REC_W        = 5 * FIELD_W;
    localparam int IN_DATA_W    = REC_W + IDX_W;
    localparam int OUT_BITS     = CNT_OUT_W + 2 + REC_W;
    localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [KEY_W-1:0] KEY_LOCAL  = 2'd0;
    localparam logic [KEY_W-1:0] KEY_PLANT  = 2'd1;
    localparam logic [KEY_W-1:0] KEY_SYSTEM = 2'd2;

    typedef struct packed {
        logic        [FIELD_W-1:0] data;
        logic signed [FIELD_W-1:0] t_sys;
        logic signed [FIELD_W-1:0] t_pla;
        logic signed [FIELD_W-1:0] t_loc;
        logic        [FIELD_W-1:0] hash;
    } t_rec;

    // neighbor status handed along the chain
    typedef struct packed {
        logic gt;    // empty or key above the incoming key
        logic kill;  // occupied slot marked for removal
        logic live;  // occupied slot that survives removal
    } t_link;

    typedef struct packed {
        logic             insert;
        logic             kill_load;
        logic             compact;
        logic [KEY_W-1:0] key_sel;
        t_rec             rec;
        logic [IDX_W-1:0] rd_idx;
    } t_cell_ctl;

    function automatic logic signed [FIELD_W-1:0] sel_key(input t_rec r,
                                                          input logic [KEY_W-1:0] ks);
        logic signed [FIELD_W-1:0] k;
        case (ks)
            KEY_LOCAL: k = r.t_loc;
            KEY_PLANT: k = r.t_pla;
            default:   k = r.t_sys;
        endcase
        return k;
    endfunction

endpackage

// ===== design/bsa_cell.sv =====
module bsa_cell #(
    parameter int CNT_W = 9,
    parameter int IDX   = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsa_pkg::t_cell_ctl          i_ctl,
    input  logic [CNT_W-1:0]            i_count,
    input  bsa_pkg::t_rec               i_left_rec,
    input  bsa_pkg::t_link              i_left_link,
    input  bsa_pkg::t_rec               i_right_rec,
    input  bsa_pkg::t_link              i_right_link,
    output bsa_pkg::t_rec               o_rec,
    output bsa_pkg::t_link              o_link,
    output logic                        o_tail,
    output logic [bsa_pkg::REC_W-1:0]   o_rd
);

    localparam int RD_W = bsa_pkg::IDX_W;
    localparam logic              RD_OK  = (IDX < (1 << RD_W));
    localparam logic [RD_W-1:0]   IDX_RD = RD_W'(IDX);
    localparam logic [CNT_W-1:0]  IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0]  IDX_C1 = CNT_W'(IDX + 1);

    bsa_pkg::t_rec              r_rec;
    logic                       r_kill;
    logic [bsa_pkg::REC_W-1:0]  r_rd;

    logic occ;
    logic gt;
    logic first;
    logic take;
    logic give;
    logic rd_hit;

    always_comb begin
        occ    = IDX_C < i_count;
        gt     = !occ || (bsa_pkg::sel_key(r_rec, i_ctl.key_sel) >
                          bsa_pkg::sel_key(i_ctl.rec, i_ctl.key_sel));
        first  = gt && !i_left_link.gt;
        take   = r_kill && occ && i_right_link.live;
        give   = !r_kill && occ && i_left_link.kill;
        rd_hit = RD_OK && occ && (i_ctl.rd_idx == IDX_RD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill <= 1'b0;
        end else if (i_ctl.kill_load) begin
            r_kill <= occ && (r_rec.hash == i_ctl.rec.hash);
        end else if (i_ctl.compact) begin
            // a hole swaps with a surviving right neighbor
            if (take) begin
                r_kill <= 1'b0;
            end else if (give) begin
                r_kill <= 1'b1;
            end
        end else begin
            r_kill <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            if (first) begin
                r_rec <= i_ctl.rec;
            end else if (gt) begin
                r_rec <= i_left_rec;
            end
        end else if (i_ctl.compact && take) begin
            r_rec <= i_right_rec;
        end
        r_rd <= rd_hit ? r_rec : '0;
    end

    assign o_rec       = r_rec;
    assign o_link.gt   = gt;
    assign o_link.kill = r_kill && occ;
    assign o_link.live = occ && !r_kill;
    assign o_tail      = r_kill && (IDX_C1 == i_count);
    assign o_rd        = r_rd;

endmodule

// ===== design/bsa_or_tree.sv =====
module bsa_or_tree #(
    parameter int N = 256,
    parameter int W = 320
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);

    localparam int L      = $clog2(N);
    localparam int LEAVES = 1 << L;

    // heap order: node k combines nodes 2k and 2k+1, root at 1
    logic [W-1:0] r_node [1:LEAVES-1];

    for (genvar k = 1; k < LEAVES; k++) begin : g_node
        if (2 * k >= LEAVES) begin : g_bot
            localparam int A = 2 * k - LEAVES;
            logic [W-1:0] a;
            logic [W-1:0] b;
            if (A < N) begin : g_a
                assign a = i_leaf[A];
            end else begin : g_az
                assign a = '0;
            end
            if (A + 1 < N) begin : g_b
                assign b = i_leaf[A+1];
            end else begin : g_bz
                assign b = '0;
            end
            always_ff @(posedge i_clk) begin
                r_node[k] <= a | b;
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                r_node[k] <= r_node[2*k] | r_node[2*k+1];
            end
        end
    end

    assign o_root = r_node[1];

endmodule

// ===== design/bounded_time_sorted_archive.sv =====
// Channel   Dir  Transaction contents
// s_axis    in   tuser: cmd; tdata: hash, local, plant, system, payload, read index
// m_axis    out  tdata: entry count, read valid, kept flag, record fields, zero pad
// cfg       in   i_cfg_wr_en / i_cfg_wr_data: sort key select, registered write
//
// Insert shifts the whole chain of cells in parallel; clear only resets the entry count.
// Read waits for the addressed record to pass the registered OR tree over the cells.
// Remove marks matching records, then holes bubble toward the tail one cell per cycle.
// Reset empties the store and sets the key select to system time.
// A stalled output holds its transaction; input waits for idle and a free output slot.
module bounded_time_sorted_archive #(
    parameter int CAPACITY = bsa_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bsa_pkg::KEY_W-1:0]         i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [63:0] signal_hash, [127:64] time_local, [191:128] time_plant,
    // [255:192] time_system, [319:256] payload, [327:320] read_index
    input  logic [bsa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  logic [bsa_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [8:0] entry_count, [9] read_valid, [10] kept_flag, [74:11] out_hash,
    // [138:75] out_local, [202:139] out_plant, [266:203] out_system,
    // [330:267] out_payload, [335:331] zero
    output logic [bsa_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int TREE_L = $clog2(CAPACITY);
    localparam int WAIT_W = $clog2(TREE_L + 2);
    localparam int IDX_W  = bsa_pkg::IDX_W;
    localparam int COW    = bsa_pkg::CNT_OUT_W;
    localparam int CMPW   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int PAD_W  = bsa_pkg::OUT_DATA_W - bsa_pkg::OUT_BITS;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPACT,
        S_READ
    } t_state;

    t_state                         r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic [CNT_W:0]                 r_budget, n_budget;
    logic [WAIT_W-1:0]              r_wait, n_wait;
    logic [IDX_W-1:0]               r_rd_idx, n_rd_idx;
    logic [bsa_pkg::KEY_W-1:0]      r_key_sel;
    logic                           r_out_valid, n_out_valid;
    logic [bsa_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                       accept;
    logic                       out_free;
    bsa_pkg::t_cmd              in_cmd;
    bsa_pkg::t_rec              in_rec;
    bsa_pkg::t_cell_ctl         ctl;
    bsa_pkg::t_rec              root_rec;
    logic                       rd_valid;
    logic [bsa_pkg::REC_W-1:0]  root;

    bsa_pkg::t_rec              cell_rec  [CAPACITY];
    bsa_pkg::t_link             cell_link [CAPACITY];
    logic [bsa_pkg::REC_W-1:0]  rd_leaf   [CAPACITY];
    logic [CAPACITY-1:0]        tail_vec;

    function automatic logic [bsa_pkg::OUT_DATA_W-1:0] pack_out(
        input logic [COW-1:0] cnt,
        input logic           valid,
        input logic           kept,
        input bsa_pkg::t_rec  r
    );
        return {{PAD_W{1'b0}}, r.data, r.t_sys, r.t_pla, r.t_loc, r.hash, kept, valid, cnt};
    endfunction

    assign in_cmd        = bsa_pkg::t_cmd'(s_axis_tuser);
    assign in_rec.hash   = s_axis_tdata[63:0];
    assign in_rec.t_loc  = s_axis_tdata[127:64];
    assign in_rec.t_pla  = s_axis_tdata[191:128];
    assign in_rec.t_sys  = s_axis_tdata[255:192];
    assign in_rec.data   = s_axis_tdata[319:256];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        ctl.insert    = accept && (in_cmd == bsa_pkg::CMD_INSERT);
        ctl.kill_load = accept && (in_cmd == bsa_pkg::CMD_REMOVE);
        ctl.compact   = (r_state == S_COMPACT) && (r_budget != '0);
        ctl.key_sel   = r_key_sel;
        ctl.rec       = in_rec;
        ctl.rd_idx    = r_rd_idx;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        bsa_pkg::t_rec  left_rec, right_rec;
        bsa_pkg::t_link left_link, right_link;
        if (i == 0) begin : g_first
            assign left_rec  = '0;
            assign left_link = '0;
        end else begin : g_mid_l
            assign left_rec  = cell_rec[i-1];
            assign left_link = cell_link[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_rec  = '0;
            assign right_link = '0;
        end else begin : g_mid_r
            assign right_rec  = cell_rec[i+1];
            assign right_link = cell_link[i+1];
        end
        bsa_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_count      (r_count),
            .i_left_rec   (left_rec),
            .i_left_link  (left_link),
            .i_right_rec  (right_rec),
            .i_right_link (right_link),
            .o_rec        (cell_rec[i]),
            .o_link       (cell_link[i]),
            .o_tail       (tail_vec[i]),
            .o_rd         (rd_leaf[i])
        );
    end

    bsa_or_tree #(
        .N (CAPACITY),
        .W (bsa_pkg::REC_W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (rd_leaf),
        .o_root (root)
    );

    assign root_rec = root;
    assign rd_valid = CMPW'(r_rd_idx) < CMPW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_budget    = r_budget;
        n_wait      = r_wait;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        bsa_pkg::CMD_INSERT: begin
                            n_count     = (r_count < CAP_C) ? r_count + 1'b1 : r_count;
                            n_out_valid = 1'b1;
                            n_out_data  = pack_out(COW'(n_count), 1'b0,
                                                   cell_link[CAPACITY-1].gt, '0);
                        end
                        bsa_pkg::CMD_REMOVE: begin
                            n_budget = {r_count, 1'b0};
                            n_state  = S_COMPACT;
                        end
                        bsa_pkg::CMD_READ: begin
                            n_rd_idx = s_axis_tdata[bsa_pkg::IN_DATA_W-1:bsa_pkg::REC_W];
                            n_wait   = WAIT_W'(TREE_L + 1);
                            n_state  = S_READ;
                        end
                        bsa_pkg::CMD_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                            n_out_data  = pack_out('0, 1'b0, 1'b0, '0);
                        end
                    endcase
                end
            end
            S_COMPACT: begin
                if (r_budget != '0) begin
                    n_budget = r_budget - 1'b1;
                    // drop a hole that has reached the tail
                    if (|tail_vec) begin
                        n_count = r_count - 1'b1;
                    end
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = pack_out(COW'(r_count), 1'b0, 1'b0, '0);
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = pack_out(COW'(r_count), rd_valid, 1'b0, root_rec);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_budget    <= '0;
            r_wait      <= '0;
            r_key_sel   <= bsa_pkg::KEY_SYSTEM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_budget    <= n_budget;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_key_sel <= i_cfg_wr_data;
            end
        end
        r_rd_idx   <= n_rd_idx;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("record count above capacity");

    a_compact_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT) |=> (r_count <= $past(r_count)))
        else $error("count grew during compaction");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_cmd == bsa_pkg::CMD_CLEAR)) |=> (r_count == '0) && r_out_valid)
        else $error("clear did not empty the store");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COMPACT) && (r_budget != '0)) |-> !s_axis_tready)
        else $error("input taken during compaction");

endmodule
